@@ hw/rtl/mbe_pkg.sv @@
// Shared types, constants and sequencer states of the escape-time pixel engine.
package mbe_pkg;

    // Fixed-point format of every coordinate: signed, FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 28;
    // Width of one z component; live values stay below 6.0 in magnitude.
    localparam int Z_W = FRAC_BITS + 4;
    // Width of a product of two z components.
    localparam int P_W = 2 * Z_W;
    // Width of a start point before its range check (offset plus 9 x 31 bit product).
    localparam int C_W = 42;

    localparam int RC_W = 9;
    localparam int VAL_W = 8;
    localparam int CFG_W = 32;
    localparam int STEP_W = 31;
    localparam int IDX_W = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_X_ORIGIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_Y_TOP = 2'd1;
    localparam logic [IDX_W-1:0] REG_STEP = 2'd2;

    // Register values after reset.
    localparam logic signed [CFG_W-1:0] X_ORIGIN_RST = 32'shE000_0000;
    localparam logic signed [CFG_W-1:0] Y_TOP_RST = 32'sh1800_0000;
    localparam logic [STEP_W-1:0] STEP_RST = 31'h0018_0000;

    // Escape value of a bounded point, and the running minimum after a frame start.
    localparam logic [VAL_W-1:0] BOUNDED_VAL = 8'hFF;
    localparam logic [VAL_W-1:0] MIN_RST = 8'hFF;

    // Escape threshold |z|^2 > 4.0, and the per-axis bound |c| > 2.0.
    localparam logic [P_W-1:0] ESC_LIMIT = P_W'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [C_W-1:0] C_LIM = C_W'(1) << (FRAC_BITS + 1);

    typedef struct packed {
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
        logic            frame_start;
    } pixel_t;

    typedef struct packed {
        logic [VAL_W-1:0] escape_value;
        logic [VAL_W-1:0] frame_min;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0] reg_index;
        logic [CFG_W-1:0] wdata;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C_RE,
        S_C_IM,
        S_RANGE,
        S_SQ_R,
        S_SQ_I,
        S_CROSS,
        S_UPDATE,
        S_FINISH
    } state_t;

endpackage

@@ hw/rtl/mbe_chan_if.sv @@
// Valid/ready channel that carries one word of a given payload type.
interface mbe_chan_if #(
    parameter type data_t = logic
) ();

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

@@ hw/rtl/mbe_mul.sv @@
// Shared signed multiplier with a registered product.
module mbe_mul (
    input  logic                        clk,
    input  logic signed [mbe_pkg::Z_W-1:0] a,
    input  logic signed [mbe_pkg::Z_W-1:0] b,
    output logic signed [mbe_pkg::P_W-1:0] p
);
    import mbe_pkg::*;

    logic signed [P_W-1:0] p_reg;

    // One full-width product per cycle, available the cycle after.
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/mandelbrot_escape_time.sv @@
// Escape-time pixel engine: one shared multiplier run by a small sequencer.
//
//  Channel  Dir  Payload                              Word accepted when
//  -------  ---  -----------------------------------  -------------------------
//  cfg      in   reg_index, wdata                     cfg.valid & cfg.ready
//  pixel    in   row, col, frame_start                pixel.valid & pixel.ready
//  result   out  escape_value, frame_min              result.valid & result.ready
//
// Each pixel runs the setup steps S_C_RE, S_C_IM and S_RANGE: two products for c
// and the range check. A start point with a component beyond 2.0 goes from there
// straight to S_FINISH. Every other start point enters the loop, where the single
// multiplier gives three products per iteration (S_SQ_R, S_SQ_I, S_CROSS) and
// S_UPDATE forms the new z; a start point outside radius two escapes at its first
// check, and a bounded point runs MAX_ITER iterations. Reset is asynchronous and
// active low; it restores the register defaults and sets the running minimum to
// 255. A finished result waits in the output register; the engine takes the next
// pixel while it waits and stalls only when a second result is ready first.
module mandelbrot_escape_time #(
    parameter int MAX_ITER = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    mbe_chan_if.sink   cfg,
    mbe_chan_if.sink   pixel,
    mbe_chan_if.source result
);
    import mbe_pkg::*;

    localparam int IW = $clog2(MAX_ITER + 1);

    state_t state_reg, state_next;

    // Configuration registers.
    logic signed [CFG_W-1:0] x_origin_reg;
    logic signed [CFG_W-1:0] y_top_reg;
    logic [STEP_W-1:0]       step_reg;

    // Pixel and iteration state.
    logic [RC_W-1:0]         row_reg, row_next;
    logic [RC_W-1:0]         col_reg, col_next;
    logic                    fs_reg, fs_next;
    logic [IW-1:0]           iter_reg, iter_next;
    logic signed [C_W-1:0]   cr_wide_reg, cr_wide_next;
    logic signed [Z_W-1:0]   cr_reg, cr_next;
    logic signed [Z_W-1:0]   ci_reg, ci_next;
    logic signed [Z_W-1:0]   zr_reg, zr_next;
    logic signed [Z_W-1:0]   zi_reg, zi_next;
    logic signed [P_W-1:0]   acc_reg, acc_next;
    logic [VAL_W-1:0]        val_reg, val_next;

    // Running minimum and output register.
    logic [VAL_W-1:0]        min_reg, min_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    // Multiplier port.
    logic signed [Z_W-1:0]   mul_a;
    logic signed [Z_W-1:0]   mul_b;
    logic signed [P_W-1:0]   prod;

    // Datapath helpers.
    logic signed [C_W-1:0]   ci_wide;
    logic [P_W-1:0]          sq_sum;
    logic [IW-1:0]           esc_n;
    logic [9:0]              five_n;
    logic [VAL_W-1:0]        esc_val;
    logic [VAL_W-1:0]        min_base;
    logic                    out_free;

    mbe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign cfg.ready = 1'b1;
    assign pixel.ready = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data = out_reg;

    // Imaginary part of c from the offset and the row product.
    assign ci_wide = C_W'(y_top_reg) - $signed(prod[C_W-1:0]);

    // Squared radius of the current z from its two squares.
    assign sq_sum = $unsigned(acc_reg) + $unsigned(prod);

    // Escape value floor(5n/2); iteration zero stands for the start point.
    assign esc_n = (iter_reg == '0) ? IW'(1) : iter_reg;
    assign five_n = (10'(esc_n) << 2) + 10'(esc_n);
    assign esc_val = five_n[VAL_W:1];

    assign min_base = fs_reg ? MIN_RST : min_reg;
    assign out_free = !out_valid_reg || result.ready;

    // Multiplier operand selection by sequencer step.
    always_comb
    begin
        unique case (state_reg)
            S_C_RE:
            begin
                mul_a = Z_W'(col_reg);
                mul_b = Z_W'(step_reg);
            end
            S_C_IM:
            begin
                mul_a = Z_W'(row_reg);
                mul_b = Z_W'(step_reg);
            end
            S_SQ_R:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_SQ_I:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    // Next state and datapath updates.
    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        fs_next = fs_reg;
        iter_next = iter_reg;
        cr_wide_next = cr_wide_reg;
        cr_next = cr_reg;
        ci_next = ci_reg;
        zr_next = zr_reg;
        zi_next = zi_reg;
        acc_next = acc_reg;
        val_next = val_reg;
        min_next = min_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pixel.valid)
                begin
                    row_next = pixel.data.row;
                    col_next = pixel.data.col;
                    fs_next = pixel.data.frame_start;
                    iter_next = '0;
                    state_next = S_C_RE;
                end
            end
            S_C_RE:
            begin
                state_next = S_C_IM;
            end
            S_C_IM:
            begin
                // Real part of c from the offset and the column product.
                cr_wide_next = C_W'(x_origin_reg) + $signed(prod[C_W-1:0]);
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                // A component beyond 2.0 already puts |c|^2 above 4.0.
                if (cr_wide_reg > C_LIM || cr_wide_reg < -C_LIM ||
                    ci_wide > C_LIM || ci_wide < -C_LIM)
                begin
                    val_next = esc_val;
                    state_next = S_FINISH;
                end
                else
                begin
                    cr_next = cr_wide_reg[Z_W-1:0];
                    ci_next = ci_wide[Z_W-1:0];
                    zr_next = cr_wide_reg[Z_W-1:0];
                    zi_next = ci_wide[Z_W-1:0];
                    state_next = S_SQ_R;
                end
            end
            S_SQ_R:
            begin
                state_next = S_SQ_I;
            end
            S_SQ_I:
            begin
                acc_next = prod;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                // acc holds zr^2 and the product zi^2.
                if (sq_sum > ESC_LIMIT)
                begin
                    val_next = esc_val;
                    state_next = S_FINISH;
                end
                else if (iter_reg == IW'(MAX_ITER))
                begin
                    val_next = BOUNDED_VAL;
                    state_next = S_FINISH;
                end
                else
                begin
                    acc_next = acc_reg - prod;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // Floor by FRAC_BITS; the cross term is doubled by one bit less.
                zr_next = acc_reg[FRAC_BITS +: Z_W] + cr_reg;
                zi_next = prod[FRAC_BITS-1 +: Z_W] + ci_reg;
                iter_next = iter_reg + IW'(1);
                state_next = S_SQ_R;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    min_next = (val_reg < min_base) ? val_reg : min_base;
                    out_next.escape_value = val_reg;
                    out_next.frame_min = (val_reg < min_base) ? val_reg : min_base;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            iter_reg <= '0;
            min_reg <= MIN_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg <= iter_next;
            min_reg <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= X_ORIGIN_RST;
            y_top_reg <= Y_TOP_RST;
            step_reg <= STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.reg_index)
                REG_X_ORIGIN: x_origin_reg <= cfg.data.wdata;
                REG_Y_TOP:    y_top_reg <= cfg.data.wdata;
                REG_STEP:     step_reg <= cfg.data.wdata[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        fs_reg <= fs_next;
        cr_wide_reg <= cr_wide_next;
        cr_reg <= cr_next;
        ci_reg <= ci_next;
        zr_reg <= zr_next;
        zi_reg <= zi_next;
        acc_reg <= acc_next;
        val_reg <= val_next;
        out_reg <= out_next;
    end

    // The minimum reported with a word never exceeds its own escape value.
    a_min_le_val: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.frame_min <= result.data.escape_value))
        else $error("frame_min above escape_value");

    // The iteration count never runs past the limit.
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iter_reg <= IW'(MAX_ITER))
        else $error("iteration count beyond MAX_ITER");

    // An accepted pixel starts the c computation in the next cycle.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> (state_reg == S_C_RE))
        else $error("accepted pixel did not start");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !result.ready) |=>
        (state_reg == S_FINISH))
        else $error("result overwrote a waiting word");

endmodule

@@ sim/mbe_pixel_checker.sv @@
// Checker that predicts the escape value and frame minimum of every pixel word and compares results.
`timescale 1ns / 1ps

module mbe_pixel_checker #(
    parameter int MAX_ITER = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  mbe_pkg::cfg_t    cfg_word,
    input  logic             pixel_valid,
    input  logic             pixel_ready,
    input  mbe_pkg::pixel_t  pixel_word,
    input  logic             result_valid,
    input  logic             result_ready,
    input  mbe_pkg::result_t result_word,
    output int               outstanding,
    output int               errors,
    output int               checked,
    output int               bounded
);
    import mbe_pkg::*;

    // Squared radius of four in the product format (2*FRAC_BITS fraction bits).
    localparam logic signed [127:0] RADIUS_LIMIT = 128'sd1 <<< (2 * FRAC_BITS + 2);

    // Local copy of the view registers and the running frame minimum.
    longint           view_re;
    longint           view_im;
    longint           pitch;
    logic [VAL_W-1:0] frame_low;

    // Escape values and frame minimums still owed by the engine, oldest first.
    result_t pending_results[$];
    int      err_count;
    int      match_count;
    int      bounded_count;

    // First iteration at which |z|^2 exceeds four, or zero when z stays bounded.
    function automatic int escape_iteration(longint c_re, longint c_im);
        logic signed [127:0] zr;
        logic signed [127:0] zi;
        logic signed [127:0] re_part;
        logic signed [127:0] im_part;
        longint              next_re;
        longint              next_im;
        int                  n;
        zr = c_re;
        zi = c_im;
        // A start point already outside radius two escapes without iterating.
        if (zr * zr + zi * zi > RADIUS_LIMIT)
            return 1;
        for (n = 1; n <= MAX_ITER; n++)
        begin
            // Exact wide products, then a floor shift back to the coordinate format.
            re_part = (zr * zr - zi * zi) >>> FRAC_BITS;
            im_part = ((zr * zi) <<< 1) >>> FRAC_BITS;
            next_re = re_part[63:0] + c_re;
            next_im = im_part[63:0] + c_im;
            zr = next_re;
            zi = next_im;
            if (zr * zr + zi * zi > RADIUS_LIMIT)
                return n;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t          want;
        longint           c_re;
        longint           c_im;
        int               n;
        logic [VAL_W-1:0] value;
        if (!rst_n)
        begin
            view_re = X_ORIGIN_RST;
            view_im = Y_TOP_RST;
            pitch = longint'(STEP_RST);
            frame_low = MIN_RST;
            pending_results.delete();
            err_count = 0;
            match_count = 0;
            bounded_count = 0;
        end
        else
        begin
            // Results first: no result can belong to a pixel taken at this same edge.
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (err_count < 10)
                        $display("%0t: result word with no pixel outstanding (escape %0d, min %0d)",
                                 $realtime, result_word.escape_value, result_word.frame_min);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_word.escape_value !== want.escape_value ||
                        result_word.frame_min !== want.frame_min)
                    begin
                        if (err_count < 10)
                            $display("%0t: escape expected %0d got %0d, frame min expected %0d got %0d",
                                     $realtime, want.escape_value, result_word.escape_value,
                                     want.frame_min, result_word.frame_min);
                        err_count++;
                    end
                    else
                        match_count++;
                end
            end

            // Register writes; an unknown index leaves the view alone.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_word.reg_index)
                    REG_X_ORIGIN: view_re = $signed(cfg_word.wdata);
                    REG_Y_TOP:    view_im = $signed(cfg_word.wdata);
                    REG_STEP:     pitch = longint'(cfg_word.wdata[STEP_W-1:0]);
                    default:      ;
                endcase
            end

            // Each accepted pixel owes exactly one result word.
            if (pixel_valid && pixel_ready)
            begin
                c_re = view_re + longint'(pixel_word.col) * pitch;
                c_im = view_im - longint'(pixel_word.row) * pitch;
                n = escape_iteration(c_re, c_im);
                value = (n == 0) ? BOUNDED_VAL : VAL_W'((5 * n) / 2);
                if (pixel_word.frame_start)
                    frame_low = MIN_RST;
                if (value < frame_low)
                    frame_low = value;
                want.escape_value = value;
                want.frame_min = frame_low;
                pending_results.push_back(want);
                if (n == 0)
                    bounded_count++;
            end
        end
        outstanding <= pending_results.size();
        errors <= err_count;
        checked <= match_count;
        bounded <= bounded_count;
    end

endmodule

@@ sim/tb_top.sv @@
// Top of the escape-time engine testbench: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
    import mbe_pkg::*;

    localparam int MAX_ITER = 100;
    // Longest pixel: a bounded point runs every iteration.
    localparam int LATENCY_MAX = 4 * MAX_ITER + 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 3_000_000;
    // Index that maps to no register.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;

    int outstanding;
    int errors;
    int checked;
    int bounded;
    int pixels_sent;
    int views_set;
    int reg_writes;
    bit tx_eager;
    bit rx_eager;

    mbe_chan_if #(.data_t(cfg_t))    cfg_ch ();
    mbe_chan_if #(.data_t(pixel_t))  pixel_ch ();
    mbe_chan_if #(.data_t(result_t)) result_ch ();

    mandelbrot_escape_time #(
        .MAX_ITER(MAX_ITER)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .pixel (pixel_ch),
        .result(result_ch)
    );

    mbe_pixel_checker #(
        .MAX_ITER(MAX_ITER)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_word    (cfg_ch.data),
        .pixel_valid (pixel_ch.valid),
        .pixel_ready (pixel_ch.ready),
        .pixel_word  (pixel_ch.data),
        .result_valid(result_ch.valid),
        .result_ready(result_ch.ready),
        .result_word (result_ch.data),
        .outstanding (outstanding),
        .errors      (errors),
        .checked     (checked),
        .bounded     (bounded)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic pixel_t pixel_at(int row, int col, bit fs);
        pixel_t word;
        word.row = RC_W'(row);
        word.col = RC_W'(col);
        word.frame_start = fs;
        return word;
    endfunction

    // Offer one pixel word after a random gap and hold it until it is taken.
    task automatic send_pixel(input pixel_t word);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data <= word;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        pixels_sent++;
    endtask

    // Stop offering pixels until every owed result has come back.
    task automatic drain_results();
        pixel_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // The caller lowers valid after the last write of a group.
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_t word;
        word.reg_index = index;
        word.wdata = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= word;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        reg_writes++;
    endtask

    // Program a new view once the engine is idle.
    task automatic apply_view(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y,
                              input logic [CFG_W-1:0] s);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_X_ORIGIN, x);
        write_reg(REG_Y_TOP, y);
        if ($urandom_range(0, 1) == 1)
            write_reg(REG_SPARE, $urandom());
        write_reg(REG_STEP, s);
        cfg_ch.valid <= 1'b0;
        views_set++;
    endtask

    // Random pixels grouped into frames of random length, with a few stray frame starts.
    task automatic run_frames(input int count);
        int i;
        int frame_left;
        bit fs;
        frame_left = 0;
        for (i = 0; i < count; i++)
        begin
            if (i % 48 == 0)
                tx_eager = ($urandom_range(0, 3) == 0);
            fs = 1'b0;
            if (frame_left == 0)
            begin
                fs = 1'b1;
                frame_left = $urandom_range(1, 40);
            end
            else if ($urandom_range(0, 63) == 0)
                fs = 1'b1;
            frame_left--;
            // Now and then hold the stream until the engine has drained.
            if ($urandom_range(0, 199) == 0)
                drain_results();
            send_pixel(pixel_at($urandom_range(0, 511), $urandom_range(0, 511), fs));
        end
    endtask

    // Result side: random stall before each word, with stretches of none.
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                rx_eager = ($urandom_range(0, 3) == 0);
            stall = rx_eager ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            taken++;
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("mandelbrot_escape_time: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.data <= '0;
        rst_n <= 1'b0;
        tx_eager = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels in the view left by reset: the four corners (two outside radius
        // two), c = -2 exactly (stays on the boundary), a point next to the origin, the cusp
        // at 0.25 and just past it, alternating bit patterns, and back-to-back frame starts.
        send_pixel(pixel_at(0, 0, 1'b1));
        send_pixel(pixel_at(0, 511, 1'b0));
        send_pixel(pixel_at(511, 0, 1'b0));
        send_pixel(pixel_at(511, 511, 1'b0));
        send_pixel(pixel_at(256, 0, 1'b1));
        send_pixel(pixel_at(256, 341, 1'b0));
        send_pixel(pixel_at(256, 384, 1'b0));
        send_pixel(pixel_at(256, 386, 1'b0));
        send_pixel(pixel_at(256, 511, 1'b0));
        send_pixel(pixel_at(0, 341, 1'b1));
        send_pixel(pixel_at(341, 170, 1'b0));
        send_pixel(pixel_at(170, 341, 1'b0));
        send_pixel(pixel_at(128, 85, 1'b0));
        send_pixel(pixel_at(300, 200, 1'b1));
        send_pixel(pixel_at(300, 200, 1'b1));
        send_pixel(pixel_at(400, 250, 1'b0));

        // Full default view, written back explicitly.
        apply_view(X_ORIGIN_RST, Y_TOP_RST, STEP_RST);
        run_frames(420);

        // Close zoom near the boundary, where many pixels run long.
        apply_view(-32'sd204010947, 32'sd32212255, 32'd16384);
        run_frames(300);

        // Zero step: every pixel is c = -1, inside the period-two bulb.
        apply_view(-32'sd268435456, 32'd0, 32'd0);
        run_frames(20);

        // Register extremes: mostly huge start points that escape at once.
        apply_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_frames(80);
        apply_view(32'h7FFF_FFFF, 32'h8000_0000, $urandom());
        run_frames(60);

        // Random views around the set.
        for (i = 0; i < 3; i++)
        begin
            apply_view(-32'sd671088640 + $urandom_range(0, 939524096),
                       $urandom_range(0, 536870912), $urandom_range(0, 1 << 21));
            run_frames(50);
        end

        // Random views over the whole register range.
        for (i = 0; i < 3; i++)
        begin
            apply_view($urandom(), $urandom(), $urandom() >> $urandom_range(0, 31));
            run_frames(40);
        end

        drain_results();
        repeat (LATENCY_MAX) @(posedge clk);
        $display("Covered %0d pixels over %0d views with %0d register writes.",
                 pixels_sent, views_set, reg_writes);
        $display("Results compared clean: %0d, predicted bounded: %0d, errors: %0d.",
                 checked, bounded, errors);
        if (errors == 0)
            $display("mandelbrot_escape_time: match");
        else
            $display("mandelbrot_escape_time: mismatch");
        $finish;
    end

endmodule
